// ===== hdl/tag_frame_text_extractor_core_assert.svh =====
// Assertion macros shared by the tag frame text extractor modules.
`ifndef TAG_FRAME_TEXT_EXTRACTOR_CORE_ASSERT_SVH
`define TAG_FRAME_TEXT_EXTRACTOR_CORE_ASSERT_SVH

// Checked property, switched off while reset is asserted.
`define TFTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked property that also holds while reset is asserted.
`define TFTE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/tfte_pkg.sv =====
// Types, constants and helpers for the tag frame text extractor.
`default_nettype none

package tfte_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgFrameId   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMaxLength = 1'b1;

  // Register reset values.
  localparam logic [31:0] FrameIdRst   = 32'h5449_5432;
  localparam logic [7:0]  MaxLengthRst = 8'd32;

  // The identifier must be found within this many leading bytes.
  localparam logic [9:0] SearchLimit = 10'd512;

  // Result kinds.
  localparam logic [1:0] KindText     = 2'd0;
  localparam logic [1:0] KindEnd      = 2'd1;
  localparam logic [1:0] KindNotFound = 2'd2;

  // Stop characters.
  localparam logic [7:0] ChT = 8'h54;
  localparam logic [7:0] ChC = 8'h43;
  localparam logic [7:0] ChP = 8'h50;
  localparam logic [7:0] ChM = 8'h4D;
  localparam logic [7:0] ChA = 8'h41;

  // Encoding byte value that selects UTF-16 with byte order mark.
  localparam logic [7:0] EncUtf16 = 8'd1;

  // Parser phases, one-hot.
  typedef enum logic [7:0] {
    PhSearch = 8'b0000_0001,
    PhToSize = 8'b0000_0010,
    PhSize   = 8'b0000_0100,
    PhToEnc  = 8'b0000_1000,
    PhEnc    = 8'b0001_0000,
    PhToText = 8'b0010_0000,
    PhText   = 8'b0100_0000,
    PhDone   = 8'b1000_0000
  } phase_e;

  // One result item.
  typedef struct packed {
    logic [7:0] text_byte;
    logic [1:0] kind;
    logic       final_res;
  } res_t;

  // Configuration values seen by the parser.
  typedef struct packed {
    logic [31:0] frame_id;
    logic [7:0]  max_length;
  } cfg_t;

  // True for a byte that may end the text.
  function automatic logic is_stop(input logic [7:0] b, input logic wide);
    logic stop;
    stop = (b == ChT) || (b == ChC) || (b == ChP) || (b == ChM);
    return stop || (wide && (b == ChA));
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tfte_cfg.sv =====
// Configuration registers of the tag frame text extractor.
`default_nettype none

module tfte_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  input  wire logic [tfte_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]                  cfg_data_i,
  output tfte_pkg::cfg_t                    cfg_o
);

  logic [31:0] frame_id_q;
  logic [7:0]  max_length_q;

  // Register writes, decoded by index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_id_q   <= tfte_pkg::FrameIdRst;
      max_length_q <= tfte_pkg::MaxLengthRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tfte_pkg::CfgFrameId:   frame_id_q   <= cfg_data_i;
        tfte_pkg::CfgMaxLength: max_length_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = '{frame_id: frame_id_q, max_length: max_length_q};

endmodule

`default_nettype wire

// ===== hdl/tfte_parser.sv =====
// Byte-by-byte frame search and text extraction state machine.
`default_nettype none

module tfte_parser (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_fire_i,
  input  wire logic [7:0]     data_byte_i,
  input  wire logic           buffer_end_i,
  input  wire tfte_pkg::cfg_t cfg_i,
  output logic                res_valid_o,
  output tfte_pkg::res_t      res_o
);

  `include "tag_frame_text_extractor_core_assert.svh"

  tfte_pkg::phase_e phase_q, phase_d;
  logic [23:0] id_window_q, id_window_d;
  logic [1:0]  skip_q, skip_d;
  logic [7:0]  copied_q, copied_d;
  logic [7:0]  text_len_q, text_len_d;
  logic [7:0]  threshold_q, threshold_d;
  logic        wide_q, wide_d;
  logic        odd_q, odd_d;
  logic [9:0]  byte_pos_q, byte_pos_d;

  logic [31:0] word;
  logic        in_window;
  logic        hit;
  logic [7:0]  limit;
  logic [7:0]  thr_full;
  logic [7:0]  copied_inc;
  logic [1:0]  skip_dec;
  logic        wide_enc;

  // Shared terms of the next-state logic.
  always_comb begin
    word       = {id_window_q, data_byte_i};
    in_window  = byte_pos_q < tfte_pkg::SearchLimit;
    hit        = (byte_pos_q >= 10'd3) && in_window && (word == cfg_i.frame_id);
    limit      = (cfg_i.max_length != 8'd0) ? cfg_i.max_length - 8'd1 : 8'd0;
    thr_full   = (text_len_q > 8'd2) ? text_len_q - 8'd2 : 8'd1;
    copied_inc = copied_q + 8'd1;
    skip_dec   = skip_q - 2'd1;
    wide_enc   = data_byte_i == tfte_pkg::EncUtf16;
  end

  // Next state and the result caused by the current byte.
  always_comb begin
    phase_d     = phase_q;
    id_window_d = id_window_q;
    skip_d      = skip_q;
    copied_d    = copied_q;
    text_len_d  = text_len_q;
    threshold_d = threshold_q;
    wide_d      = wide_q;
    odd_d       = odd_q;
    byte_pos_d  = byte_pos_q;
    res_valid_o = 1'b0;
    res_o       = '{text_byte: 8'd0, kind: tfte_pkg::KindEnd, final_res: 1'b1};

    unique case (phase_q)
      tfte_pkg::PhSearch: begin
        id_window_d = word[23:0];
        if (in_window) begin
          byte_pos_d = byte_pos_q + 10'd1;
        end
        if (hit) begin
          phase_d     = tfte_pkg::PhToSize;
          skip_d      = 2'd3;
          res_valid_o = buffer_end_i;
        end else begin
          res_valid_o = buffer_end_i;
          res_o.kind  = tfte_pkg::KindNotFound;
        end
      end
      tfte_pkg::PhToSize, tfte_pkg::PhToEnc, tfte_pkg::PhToText: begin
        skip_d      = skip_dec;
        res_valid_o = buffer_end_i;
        if (skip_dec == 2'd0) begin
          case (phase_q)
            tfte_pkg::PhToSize: phase_d = tfte_pkg::PhSize;
            tfte_pkg::PhToEnc:  phase_d = tfte_pkg::PhEnc;
            default:            phase_d = tfte_pkg::PhText;
          endcase
        end
      end
      tfte_pkg::PhSize: begin
        text_len_d  = (data_byte_i > limit) ? limit : data_byte_i;
        phase_d     = tfte_pkg::PhToEnc;
        skip_d      = 2'd2;
        res_valid_o = buffer_end_i;
      end
      tfte_pkg::PhEnc: begin
        wide_d      = wide_enc;
        threshold_d = wide_enc ? {1'b0, thr_full[7:1]} : thr_full;
        copied_d    = 8'd0;
        odd_d       = 1'b0;
        if (text_len_q == 8'd0) begin
          phase_d     = tfte_pkg::PhDone;
          res_valid_o = 1'b1;
        end else begin
          res_valid_o = buffer_end_i;
          if (wide_enc) begin
            phase_d = tfte_pkg::PhToText;
            skip_d  = 2'd2;
          end else begin
            phase_d = tfte_pkg::PhText;
          end
        end
      end
      tfte_pkg::PhText: begin
        if (odd_q) begin
          // Second byte of a UTF-16 unit is dropped.
          odd_d       = 1'b0;
          res_valid_o = buffer_end_i;
        end else if ((copied_q >= threshold_q) && tfte_pkg::is_stop(data_byte_i, wide_q)) begin
          phase_d     = tfte_pkg::PhDone;
          res_valid_o = 1'b1;
        end else begin
          copied_d        = copied_inc;
          odd_d           = wide_q;
          res_valid_o     = 1'b1;
          res_o.text_byte = data_byte_i;
          res_o.kind      = tfte_pkg::KindText;
          if (copied_inc >= text_len_q) begin
            phase_d = tfte_pkg::PhDone;
          end else begin
            res_o.final_res = buffer_end_i;
          end
        end
      end
      tfte_pkg::PhDone: ;
      default: phase_d = tfte_pkg::PhSearch;
    endcase

    // The end of every buffer starts a fresh search.
    if (buffer_end_i) begin
      phase_d     = tfte_pkg::PhSearch;
      id_window_d = 24'd0;
      skip_d      = 2'd0;
      copied_d    = 8'd0;
      text_len_d  = 8'd0;
      threshold_d = 8'd0;
      wide_d      = 1'b0;
      odd_d       = 1'b0;
      byte_pos_d  = 10'd0;
    end
  end

  // State registers advance only on an accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= tfte_pkg::PhSearch;
      id_window_q <= 24'd0;
      skip_q      <= 2'd0;
      copied_q    <= 8'd0;
      text_len_q  <= 8'd0;
      threshold_q <= 8'd0;
      wide_q      <= 1'b0;
      odd_q       <= 1'b0;
      byte_pos_q  <= 10'd0;
    end else if (in_fire_i) begin
      phase_q     <= phase_d;
      id_window_q <= id_window_d;
      skip_q      <= skip_d;
      copied_q    <= copied_d;
      text_len_q  <= text_len_d;
      threshold_q <= threshold_d;
      wide_q      <= wide_d;
      odd_q       <= odd_d;
      byte_pos_q  <= byte_pos_d;
    end
  end

  // Every buffer end outside the idle phase closes with a final result.
  `TFTE_ASSERT(a_end_gives_final, in_fire_i && buffer_end_i && (phase_q != tfte_pkg::PhDone) |-> res_valid_o && res_o.final_res, "buffer end without final result")
  // A buffer end always returns the parser to the search.
  `TFTE_ASSERT(a_end_restarts, in_fire_i && buffer_end_i |=> phase_q == tfte_pkg::PhSearch, "no restart after buffer end")
  // Only text results carry a byte.
  `TFTE_ASSERT(a_byte_only_text, res_valid_o && (res_o.kind != tfte_pkg::KindText) |-> res_o.text_byte == 8'd0, "byte on non-text result")
  // The search position never runs past the limit.
  `TFTE_ASSERT(a_pos_bound, byte_pos_q <= tfte_pkg::SearchLimit, "search position overrun")

endmodule

`default_nettype wire

// ===== hdl/tfte_out_stage.sv =====
// Output register with a skid entry so input and output stalls are decoupled.
`default_nettype none

module tfte_out_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire tfte_pkg::res_t res_i,
  output logic                ready_o,
  output logic                valid_o,
  input  wire logic           take_i,
  output tfte_pkg::res_t      res_o
);

  `include "tag_frame_text_extractor_core_assert.svh"

  logic           out_valid_q, skid_valid_q;
  tfte_pkg::res_t out_q, skid_q;
  logic           pop;

  assign pop     = out_valid_q && take_i;
  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign res_o   = out_q;

  // Valid flags of the output and skid entries.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload of the output and skid entries.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (out_valid_q && !pop) begin
        skid_q <= res_i;
      end else begin
        out_q <= res_i;
      end
    end
  end

  // The skid entry is only used behind a full output register.
  `TFTE_ASSERT(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid entry without output entry")
  // A push is never offered while the stage is full.
  `TFTE_ASSERT(a_no_push_full, skid_valid_q |-> !push_i, "push into full stage")
  // The reserved kind code never reaches the output.
  `TFTE_ASSERT(a_kind_legal, out_valid_q |-> !(out_q.kind[1] && out_q.kind[0]), "illegal result kind")

endmodule

`default_nettype wire

// ===== hdl/tag_frame_text_extractor_core.sv =====
// Top level of the tag frame text extractor.
// The slave stream carries the tag buffer one byte per item in tdata, with tlast
// on the final byte. The block looks for the configured four-character frame
// identifier, reads the size and encoding header and emits the frame text on the
// master stream: tdata holds the text byte, tuser the result kind (0 text byte,
// 1 end of text, 2 frame not found) and tlast marks the last result of a buffer.
// A byte gives zero or one result; one item is taken per cycle while input ready
// is high, so throughput is then one byte per clock. Each result is registered
// in the output register behind the parser logic. When the receiver stalls, one
// further result is held in a skid entry and input ready then falls until the
// output drains; no result is lost or repeated. Reset clears the search state
// and returns frame_id to "TIT2" and max_length to 32; no clearing pass is needed.
// The configuration channel is always ready and is written by the user only
// while the block is idle, not enforced by it: index 0 frame_id, 1 max_length.
`default_nettype none

module tag_frame_text_extractor_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Slave stream.
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  wire logic [7:0]                   s_axis_tdata_i,  // [7:0] data_byte
  input  wire logic                         s_axis_tlast_i,  // buffer_end
  // Master stream.
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  output logic [7:0]                        m_axis_tdata_o,  // [7:0] text_byte
  output logic [1:0]                        m_axis_tuser_o,  // [1:0] kind
  output logic                              m_axis_tlast_o,  // final_res
  // Configuration write channel.
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [tfte_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]                  cfg_data_i
);

  tfte_pkg::cfg_t cfg;
  tfte_pkg::res_t res, out_res;
  logic           res_valid;
  logic           in_fire;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = s_axis_tvalid_i && s_axis_tready_o;

  tfte_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tfte_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_fire_i    (in_fire),
    .data_byte_i  (s_axis_tdata_i),
    .buffer_end_i (s_axis_tlast_i),
    .cfg_i        (cfg),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  tfte_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_fire && res_valid),
    .res_i   (res),
    .ready_o (s_axis_tready_o),
    .valid_o (m_axis_tvalid_o),
    .take_i  (m_axis_tready_i),
    .res_o   (out_res)
  );

  assign m_axis_tdata_o = out_res.text_byte;
  assign m_axis_tuser_o = out_res.kind;
  assign m_axis_tlast_o = out_res.final_res;

endmodule

`default_nettype wire

// ===== dv/tb_tag_frame_text_extractor_core.sv =====
// Self-checking testbench for the tag frame text extractor core with a byte-level parser predictor.
module tb_tag_frame_text_extractor_core;
  import tfte_pkg::*;

  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned IdleLimit   = 3000;
  localparam int unsigned DrainCycles = 8;

  // One buffer byte as offered on the slave stream.
  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } tag_item_t;

  logic               clk_i  = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_valid = 1'b0;
  logic               s_ready;
  logic [7:0]         s_data = 8'h00;
  logic               s_last = 1'b0;
  logic               m_valid;
  logic               m_ready = 1'b0;
  logic [7:0]         m_data;
  logic [1:0]         m_user;
  logic               m_last;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = CfgFrameId;
  logic [31:0]        cfg_data = 32'h0;

  // Traffic control shared by the stimulus, the sender and the receiver.
  tag_item_t   tag_items_q[$];
  logic [7:0]  tag_bytes[$];
  int unsigned queued_count = 0;
  logic        steady = 1'b0;
  logic        hold_req = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;
  logic [31:0] gen_id = FrameIdRst;
  logic [7:0]  gen_max = MaxLengthRst;

  // Predictor state and its copy of the registers.
  res_t        pending_results[$];
  logic [31:0] exp_frame_id = FrameIdRst;
  logic [7:0]  exp_max_length = MaxLengthRst;
  logic [23:0] last_three = '0;
  phase_e      parse_ph = PhSearch;
  logic [2:0]  skip_left = '0;
  logic [7:0]  copied = '0;
  logic [7:0]  text_len = '0;
  logic [7:0]  stop_at = '0;
  logic        wide = 1'b0;
  logic        odd_skip = 1'b0;
  logic [9:0]  seen_bytes = '0;
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;

  tag_frame_text_extractor_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  function automatic res_t make_res(input logic [7:0] b, input logic [1:0] k, input logic f);
    res_t r;
    r.text_byte = b;
    r.kind      = k;
    r.final_res = f;
    return r;
  endfunction

  // True for a byte that may end the text once the threshold is reached.
  function automatic logic ends_text(input logic [7:0] b, input logic utf16);
    case (b)
      ChT, ChC, ChP, ChM: return 1'b1;
      ChA:                return utf16;
      default:            return 1'b0;
    endcase
  endfunction

  // Advances the parser by one buffer byte and gives the result it causes, if any.
  task automatic extract_step(input logic [7:0] b, input logic is_last,
                              output logic has_res, output res_t r);
    logic [31:0] word;
    logic [7:0]  lim;
    logic        hit;
    has_res = 1'b0;
    r = make_res(8'h00, KindEnd, 1'b1);
    case (parse_ph)
      PhSearch: begin
        word = {last_three, b};
        hit = (seen_bytes >= 10'd3) && (seen_bytes < SearchLimit) && (word == exp_frame_id);
        last_three = word[23:0];
        if (seen_bytes < SearchLimit) seen_bytes = seen_bytes + 10'd1;
        if (hit) begin
          parse_ph = PhToSize;
          skip_left = 3'd3;
          has_res = is_last;
        end else if (is_last) begin
          has_res = 1'b1;
          r = make_res(8'h00, KindNotFound, 1'b1);
        end
      end
      PhToSize, PhToEnc, PhToText: begin
        skip_left = skip_left - 3'd1;
        if (skip_left == 3'd0) begin
          case (parse_ph)
            PhToSize: parse_ph = PhSize;
            PhToEnc:  parse_ph = PhEnc;
            default:  parse_ph = PhText;
          endcase
        end
        has_res = is_last;
      end
      PhSize: begin
        lim = (exp_max_length != 8'd0) ? exp_max_length - 8'd1 : 8'd0;
        text_len = (b > lim) ? lim : b;
        parse_ph = PhToEnc;
        skip_left = 3'd2;
        has_res = is_last;
      end
      PhEnc: begin
        wide = (b == EncUtf16);
        stop_at = (text_len > 8'd2) ? text_len - 8'd2 : 8'd1;
        if (wide) stop_at = stop_at >> 1;
        copied = 8'd0;
        odd_skip = 1'b0;
        if (text_len == 8'd0) begin
          // Zero size ends the text on the encoding byte itself.
          parse_ph = PhDone;
          has_res = 1'b1;
        end else begin
          if (wide) begin
            parse_ph = PhToText;
            skip_left = 3'd2;
          end else begin
            parse_ph = PhText;
          end
          has_res = is_last;
        end
      end
      PhText: begin
        if (odd_skip) begin
          odd_skip = 1'b0;
          has_res = is_last;
        end else if (copied >= stop_at && ends_text(b, wide)) begin
          parse_ph = PhDone;
          has_res = 1'b1;
        end else begin
          copied = copied + 8'd1;
          odd_skip = wide;
          has_res = 1'b1;
          if (copied >= text_len) begin
            parse_ph = PhDone;
            r = make_res(b, KindText, 1'b1);
          end else begin
            r = make_res(b, KindText, is_last);
          end
        end
      end
      default: ;
    endcase
    // Every buffer end restarts the search with the registers untouched.
    if (is_last) begin
      last_three = '0;
      parse_ph = PhSearch;
      skip_left = '0;
      copied = '0;
      text_len = '0;
      stop_at = '0;
      wide = 1'b0;
      odd_skip = 1'b0;
      seen_bytes = '0;
    end
  endtask

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= 100) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Sender: offers the next queued item, with random gaps.
  always @(posedge clk_i) begin : sender
    tag_item_t item;
    if (rst_ni && (!s_valid || s_ready)) begin
      if (tag_items_q.size() != 0 && (steady || $urandom_range(0, 99) >= 26)) begin
        item = tag_items_q.pop_front();
        s_valid <= 1'b1;
        s_data <= item.data;
        s_last <= item.is_last;
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  always @(posedge clk_i) begin : receiver
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HoldCycles;
      m_ready <= 1'b0;
    end else begin
      m_ready <= steady || ($urandom_range(0, 99) >= 26);
    end
  end

  // Monitor: tracks register writes, predicts each accepted item and checks each result.
  always @(posedge clk_i) begin : monitor
    logic got;
    res_t want;
    logic active;
    if (rst_ni) begin
      active = 1'b0;
      if (cfg_valid && cfg_ready) begin
        active = 1'b1;
        case (cfg_index)
          CfgFrameId:   exp_frame_id = cfg_data;
          CfgMaxLength: exp_max_length = cfg_data[7:0];
          default: ;
        endcase
      end
      if (s_valid && s_ready) begin
        active = 1'b1;
        extract_step(s_data, s_last, got, want);
        if (got) pending_results.push_back(want);
      end
      if (m_valid && m_ready) begin
        active = 1'b1;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result: byte %02h kind %0d last %0b",
                                    m_data, m_user, m_last));
        end else begin
          want = pending_results.pop_front();
          if (m_data !== want.text_byte)
            report_mismatch($sformatf("text byte %02h, wanted %02h", m_data, want.text_byte));
          if (m_user !== want.kind)
            report_mismatch($sformatf("kind %0d, wanted %0d", m_user, want.kind));
          if (m_last !== want.final_res)
            report_mismatch($sformatf("final flag %0b, wanted %0b", m_last, want.final_res));
        end
      end
      idle_cycles = active ? 0 : idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [31:0] id, input logic [7:0] max_len);
    write_reg(CfgFrameId, id);
    write_reg(CfgMaxLength, {24'h0, max_len});
    gen_id = id;
    gen_max = max_len;
  endtask

  // Waits until every item is taken and every result has come, then lets the pipe settle.
  task automatic wait_idle();
    while (tag_items_q.size() != 0 || s_valid || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Moves the assembled buffer into the send queue, marking its final byte.
  task automatic push_tag_bytes();
    foreach (tag_bytes[i])
      tag_items_q.push_back(tag_item_t'{tag_bytes[i], i == tag_bytes.size() - 1});
    queued_count += tag_bytes.size();
    tag_bytes.delete();
  endtask

  function automatic logic [7:0] text_char();
    if ($urandom_range(0, 4) != 0) return 8'($urandom);
    case ($urandom_range(0, 4))
      0:       return ChT;
      1:       return ChC;
      2:       return ChP;
      3:       return ChM;
      default: return ChA;
    endcase
  endfunction

  task automatic push_id();
    int k;
    for (k = 3; k >= 0; k--) tag_bytes.push_back(gen_id[8*k +: 8]);
  endtask

  // A well-formed frame with random content, sometimes cut short anywhere.
  task automatic queue_frame(input int unsigned lead, input logic allow_cut);
    int unsigned size;
    int unsigned span;
    int unsigned cut;
    logic [7:0]  enc;
    logic [7:0]  lim;
    repeat (lead) tag_bytes.push_back(8'($urandom));
    push_id();
    repeat (3) tag_bytes.push_back(8'($urandom));
    case ($urandom_range(0, 19))
      0:       size = 0;
      1:       size = 255;
      2, 3:    size = $urandom_range(0, 255);
      default: size = $urandom_range(1, 12);
    endcase
    tag_bytes.push_back(8'(size));
    repeat (2) tag_bytes.push_back(8'($urandom));
    if ($urandom_range(0, 1) != 0) enc = EncUtf16;
    else if ($urandom_range(0, 3) == 0) enc = 8'($urandom);
    else enc = 8'h00;
    tag_bytes.push_back(enc);
    lim = (gen_max != 8'd0) ? gen_max - 8'd1 : 8'd0;
    span = (size > lim) ? lim : size;
    if (enc == EncUtf16) begin
      repeat (2) tag_bytes.push_back(8'($urandom));
      span = 2 * span;
    end
    span += $urandom_range(0, 3);
    repeat (span) tag_bytes.push_back(text_char());
    if (allow_cut && $urandom_range(0, 6) == 0) begin
      cut = $urandom_range(1, tag_bytes.size());
      while (tag_bytes.size() > cut) void'(tag_bytes.pop_back());
    end
    push_tag_bytes();
  endtask

  // Mostly frames, with some buffers of pure noise.
  task automatic queue_random(input int unsigned n_items);
    int unsigned goal;
    goal = queued_count + n_items;
    while (queued_count < goal) begin
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 12)) tag_bytes.push_back(8'($urandom));
        push_tag_bytes();
      end else begin
        queue_frame(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6), 1'b1);
      end
    end
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset registers. Zero size, then bytes after the final result until the end.
    push_id();
    repeat (3) tag_bytes.push_back(8'h00);
    tag_bytes.push_back(8'h00);
    repeat (2) tag_bytes.push_back(8'hFF);
    tag_bytes.push_back(8'h00);
    tag_bytes.push_back(8'h78);
    tag_bytes.push_back(8'h00);
    push_tag_bytes();
    // A one-byte buffer with no identifier.
    tag_bytes.push_back(8'hFF);
    push_tag_bytes();
    // The buffer ends on the byte that completes the identifier.
    push_id();
    push_tag_bytes();
    tag_bytes.push_back(8'h00);
    push_tag_bytes();
    queue_random(90);
    wait_idle();

    // Lowest identifier and smallest legal capacity.
    set_config(32'h0000_0000, 8'd2);
    queue_random(70);
    wait_idle();

    // Highest values, with the receiver holding off while buffers keep coming.
    set_config(32'hFFFF_FFFF, 8'd255);
    @(posedge clk_i);
    hold_req <= ~hold_req;
    queue_random(90);
    wait_idle();

    // Capacity of one; the identifier matches the first byte alone, too early for a hit.
    set_config({24'h0, 8'($urandom_range(1, 255))}, 8'd1);
    tag_bytes.push_back(gen_id[7:0]);
    push_tag_bytes();
    queue_random(50);
    wait_idle();

    // Capacity of zero.
    set_config($urandom, 8'd0);
    queue_random(40);
    wait_idle();

    // No idling on either side; identifiers right at and just past the search limit.
    steady <= 1'b1;
    set_config($urandom, 8'($urandom_range(2, 255)));
    queue_random(30);
    queue_frame(508, 1'b0);
    queue_frame(509, 1'b0);
    queue_random(20);
    wait_idle();
    steady <= 1'b0;

    // Back to the reset values.
    set_config(FrameIdRst, MaxLengthRst);
    queue_random(50);
    wait_idle();

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== tag_frame_text_extractor_core.f =====
+incdir+hdl
hdl/tfte_pkg.sv
hdl/tfte_cfg.sv
hdl/tfte_parser.sv
hdl/tfte_out_stage.sv
hdl/tag_frame_text_extractor_core.sv
dv/tb_tag_frame_text_extractor_core.sv
